@@ rtl/uvs_pkg.sv @@
package uvs_pkg;

  localparam int MaxBlocks      = 255;
  localparam int AngleBitsDef   = 16;
  localparam int TrigStagesDef  = 16;
  localparam int CountW         = 8;
  localparam int RadiusW        = 24;
  localparam int PosW           = 26;
  localparam int TexW           = 17;
  localparam int CfgIdxW        = 2;
  localparam int CfgDataW       = 24;
  localparam int CordW          = 33;
  localparam int AtanTableLen   = 24;

  localparam logic [CountW-1:0]  SegmentsReset = 8'd16;
  localparam logic [CountW-1:0]  RingsReset    = 8'd8;
  localparam logic [RadiusW-1:0] RadiusReset   = 24'd65536;

  localparam logic signed [CordW-1:0] GainQ30 = 33'sd652032874;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSegments = 2'd0,
    CfgRings    = 2'd1,
    CfgRadius   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [CordW-1:0] z;
    logic [1:0]              quad;
  } cord_lane_t;

  typedef struct packed {
    logic [TexW-1:0] u;
    logic [TexW-1:0] v;
  } tex_t;

  function automatic logic [CountW-1:0] clamp_count(input logic [CountW-1:0] n);
    logic [CountW-1:0] r;
    r = n;
    if (n == '0) r = CountW'(1);
    else if (32'(n) > MaxBlocks) r = CountW'(MaxBlocks);
    return r;
  endfunction

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051D;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2E;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2F9;
      15: a = 32'h0000517C;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A2F;
      19: a = 32'h00000517;
      20: a = 32'h0000028B;
      21: a = 32'h00000145;
      22: a = 32'h000000A2;
      23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/uvs_in_if.sv @@
interface uvs_in_if import uvs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] ring_index;
  logic [CountW-1:0] segment_index;

  modport source (output valid, ring_index, segment_index, input ready);
  modport sink (input valid, ring_index, segment_index, output ready);
endinterface

@@ rtl/uvs_out_if.sv @@
interface uvs_out_if import uvs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic signed [PosW-1:0] pos_z;
  logic [TexW-1:0]        tex_u;
  logic [TexW-1:0]        tex_v;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

@@ rtl/uvs_div_cell.sv @@
module uvs_div_cell import uvs_pkg::*; #(
  parameter int QuotW = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CountW-1:0] row_cnt_i,
  input  logic [CountW-1:0] col_cnt_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [CountW-1:0] row_rem_i,
  input  logic [QuotW-1:0]  row_quo_i,
  input  logic [CountW-1:0] col_rem_i,
  input  logic [QuotW-1:0]  col_quo_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [CountW-1:0] row_rem_o,
  output logic [QuotW-1:0]  row_quo_o,
  output logic [CountW-1:0] col_rem_o,
  output logic [QuotW-1:0]  col_quo_o
);

  logic [CountW:0]   row_sh, col_sh;
  logic              row_ge, col_ge;
  logic [CountW-1:0] row_rem_d, col_rem_d, row_rem_q, col_rem_q;
  logic [QuotW-1:0]  row_quo_d, col_quo_d, row_quo_q, col_quo_q;
  logic              valid_q;

  // one quotient bit per cell, remainder stays below the count
  always_comb begin
    row_sh    = {row_rem_i, 1'b0};
    col_sh    = {col_rem_i, 1'b0};
    row_ge    = row_sh >= {1'b0, row_cnt_i};
    col_ge    = col_sh >= {1'b0, col_cnt_i};
    row_rem_d = row_ge ? CountW'(row_sh - {1'b0, row_cnt_i}) : row_sh[CountW-1:0];
    col_rem_d = col_ge ? CountW'(col_sh - {1'b0, col_cnt_i}) : col_sh[CountW-1:0];
    row_quo_d = {row_quo_i[QuotW-2:0], row_ge};
    col_quo_d = {col_quo_i[QuotW-2:0], col_ge};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      row_rem_q <= row_rem_d;
      col_rem_q <= col_rem_d;
      row_quo_q <= row_quo_d;
      col_quo_q <= col_quo_d;
    end
  end

  assign valid_o   = valid_q;
  assign row_rem_o = row_rem_q;
  assign col_rem_o = col_rem_q;
  assign row_quo_o = row_quo_q;
  assign col_quo_o = col_quo_q;

endmodule

@@ rtl/uvs_cordic_cell.sv @@
module uvs_cordic_cell import uvs_pkg::*; #(
  parameter int Idx = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  cord_lane_t el_i,
  input  cord_lane_t az_i,
  input  tex_t       tex_i,
  output logic       valid_o,
  input  logic       ready_i,
  output cord_lane_t el_o,
  output cord_lane_t az_o,
  output tex_t       tex_o
);

  localparam logic signed [CordW-1:0] Atan = CordW'(atan_turn(Idx));

  cord_lane_t el_d, az_d, el_q, az_q;
  tex_t       tex_q;
  logic       valid_q;

  function automatic cord_lane_t rotate(input cord_lane_t l);
    cord_lane_t r;
    logic signed [CordW-1:0] x, y, z;
    x = l.x;
    y = l.y;
    z = l.z;
    r.quad = l.quad;
    if (!z[CordW-1]) begin
      r.x = x - (y >>> Idx);
      r.y = y + (x >>> Idx);
      r.z = z - Atan;
    end else begin
      r.x = x + (y >>> Idx);
      r.y = y - (x >>> Idx);
      r.z = z + Atan;
    end
    return r;
  endfunction

  assign el_d    = rotate(el_i);
  assign az_d    = rotate(az_i);
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      el_q  <= el_d;
      az_q  <= az_d;
      tex_q <= tex_i;
    end
  end

  assign valid_o = valid_q;
  assign el_o    = el_q;
  assign az_o    = az_q;
  assign tex_o   = tex_q;

endmodule

@@ rtl/uvs_scale.sv @@
module uvs_scale import uvs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [RadiusW-1:0]     radius_i,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  cord_lane_t             el_i,
  input  cord_lane_t             az_i,
  input  tex_t                   tex_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic signed [PosW-1:0] pos_x_o,
  output logic signed [PosW-1:0] pos_y_o,
  output logic signed [PosW-1:0] pos_z_o,
  output tex_t                   tex_o
);

  localparam int ProdW = RadiusW + 1 + CordW;
  localparam int TW    = 36;
  localparam int FinW  = TW + CordW;

  logic [4:0] v_q;
  logic [5:0] en;

  logic signed [CordW-1:0] ce_q, se_q, ca1_q, sa1_q, ca2_q, sa2_q, ca3_q, sa3_q;
  logic signed [ProdW-1:0] py_p_q, t_p_q;
  logic signed [PosW-1:0]  py3_q, py4_q, py5_q, px5_q, pz5_q;
  logic signed [TW-1:0]    t_q;
  logic signed [FinW-1:0]  px_p_q, pz_p_q;
  tex_t                    tex1_q, tex2_q, tex3_q, tex4_q, tex5_q;

  logic signed [CordW-1:0] ce_d, se_d, ca_d, sa_d;
  logic signed [ProdW-1:0] py_r, t_r;
  logic signed [FinW-1:0]  px_r, pz_r;

  function automatic logic signed [PosW-1:0] sat_pos(input logic signed [FinW-1:0] v);
    logic signed [FinW-1:0] lim;
    logic signed [PosW-1:0] r;
    lim = FinW'(1) <<< 24;
    if (v > lim) r = PosW'(lim);
    else if (v < -lim) r = PosW'(-lim);
    else r = PosW'(v);
    return r;
  endfunction

  always_comb begin
    unique case (el_i.quad)
      2'd0: begin ce_d = el_i.x;  se_d = el_i.y;  end
      2'd1: begin ce_d = -el_i.y; se_d = el_i.x;  end
      2'd2: begin ce_d = -el_i.x; se_d = -el_i.y; end
      default: begin ce_d = el_i.y; se_d = -el_i.x; end
    endcase
    unique case (az_i.quad)
      2'd0: begin ca_d = az_i.x;  sa_d = az_i.y;  end
      2'd1: begin ca_d = -az_i.y; sa_d = az_i.x;  end
      2'd2: begin ca_d = -az_i.x; sa_d = -az_i.y; end
      default: begin ca_d = az_i.y; sa_d = -az_i.x; end
    endcase
  end

  assign py_r = (py_p_q + (ProdW'(1) <<< 29)) >>> 30;
  assign t_r  = (t_p_q + (ProdW'(1) <<< 21)) >>> 22;
  assign px_r = (px_p_q + (FinW'(1) <<< 37)) >>> 38;
  assign pz_r = (pz_p_q + (FinW'(1) <<< 37)) >>> 38;

  // per-stage handshake so bubbles collapse under a stalled output
  always_comb begin
    en[5] = ready_i;
    for (int k = 4; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < 5; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) begin
      ce_q   <= ce_d;
      se_q   <= se_d;
      ca1_q  <= ca_d;
      sa1_q  <= sa_d;
      tex1_q <= tex_i;
    end
    if (en[1] && v_q[0]) begin
      py_p_q <= $signed({1'b0, radius_i}) * se_q;
      t_p_q  <= $signed({1'b0, radius_i}) * ce_q;
      ca2_q  <= ca1_q;
      sa2_q  <= sa1_q;
      tex2_q <= tex1_q;
    end
    if (en[2] && v_q[1]) begin
      py3_q  <= sat_pos(FinW'(py_r));
      t_q    <= TW'(t_r);
      ca3_q  <= ca2_q;
      sa3_q  <= sa2_q;
      tex3_q <= tex2_q;
    end
    if (en[3] && v_q[2]) begin
      px_p_q <= t_q * ca3_q;
      pz_p_q <= t_q * sa3_q;
      py4_q  <= py3_q;
      tex4_q <= tex3_q;
    end
    if (en[4] && v_q[3]) begin
      px5_q  <= sat_pos(px_r);
      pz5_q  <= sat_pos(pz_r);
      py5_q  <= py4_q;
      tex5_q <= tex4_q;
    end
  end

  assign valid_o = v_q[4];
  assign pos_x_o = px5_q;
  assign pos_y_o = py5_q;
  assign pos_z_o = pz5_q;
  assign tex_o   = tex5_q;

endmodule

@@ rtl/uv_sphere_vertex_generator_core.sv @@
// channel    dir  handshake     payload
// in_i       in   valid/ready   ring_index, segment_index
// out_o      out  valid/ready   pos_x, pos_y, pos_z, tex_u, tex_v
// cfg        in   cfg_we_i      cfg_idx_i, cfg_data_i
// one item per cycle while out_o is ready, every cell of the chain holds one item
// the chain is K = max(ANGLE_BITS, 16) + 1 divider cells, TRIG_STAGES cordic cells and
// five quadrant, multiply and rounding stages: one quotient bit per divider cell, one
// rotation per cordic cell
// reset clears all valid bits and loads the register defaults
// each cell stalls only when full and its neighbor is stalled, so bubbles collapse
module uv_sphere_vertex_generator_core import uvs_pkg::*; #(
  parameter int ANGLE_BITS  = AngleBitsDef,
  parameter int TRIG_STAGES = TrigStagesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  uvs_in_if.sink              in_i,
  uvs_out_if.source           out_o
);

  localparam int K     = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 1;
  localparam int QuotW = K + 1;

  logic [CountW-1:0]  seg_q, ring_q;
  logic [RadiusW-1:0] radius_q;
  logic [CountW-1:0]  cols, rows, row_c, col_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q    <= SegmentsReset;
      ring_q   <= RingsReset;
      radius_q <= RadiusReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgSegments: seg_q    <= cfg_data_i[CountW-1:0];
        CfgRings:    ring_q   <= cfg_data_i[CountW-1:0];
        CfgRadius:   radius_q <= cfg_data_i[RadiusW-1:0];
        default: ;
      endcase
    end
  end

  assign cols  = clamp_count(seg_q);
  assign rows  = clamp_count(ring_q);
  assign row_c = (in_i.ring_index > rows) ? rows : in_i.ring_index;
  assign col_c = (in_i.segment_index > cols) ? cols : in_i.segment_index;

  // divider chain: quotient of index * 2^K over count
  logic [K:0]        dv, dr;
  logic [CountW-1:0] row_rem [K+1];
  logic [CountW-1:0] col_rem [K+1];
  logic [QuotW-1:0]  row_quo [K+1];
  logic [QuotW-1:0]  col_quo [K+1];

  assign dv[0]      = in_i.valid;
  assign in_i.ready = dr[0];
  assign row_rem[0] = (row_c == rows) ? '0 : row_c;
  assign col_rem[0] = (col_c == cols) ? '0 : col_c;
  assign row_quo[0] = QuotW'(row_c == rows);
  assign col_quo[0] = QuotW'(col_c == cols);

  for (genvar g = 0; g < K; g++) begin : g_div
    uvs_div_cell #(.QuotW(QuotW)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .row_cnt_i (rows),
      .col_cnt_i (cols),
      .valid_i   (dv[g]),
      .ready_o   (dr[g]),
      .row_rem_i (row_rem[g]),
      .row_quo_i (row_quo[g]),
      .col_rem_i (col_rem[g]),
      .col_quo_i (col_quo[g]),
      .valid_o   (dv[g+1]),
      .ready_i   (dr[g+1]),
      .row_rem_o (row_rem[g+1]),
      .row_quo_o (row_quo[g+1]),
      .col_rem_o (col_rem[g+1]),
      .col_quo_o (col_quo[g+1])
    );
  end

  // angles and texture coordinates, rounded half up
  logic [QuotW:0]        el_rnd, az_rnd, tu_rnd, tv_rnd;
  logic [ANGLE_BITS-1:0] el_ang, az_ang;

  always_comb begin
    el_rnd = ((QuotW+1)'(row_quo[K] >> (K - ANGLE_BITS)) + 1'b1) >> 1;
    az_rnd = ((QuotW+1)'(col_quo[K] >> (K - ANGLE_BITS - 1)) + 1'b1) >> 1;
    tv_rnd = ((QuotW+1)'(row_quo[K] >> (K - TexW)) + 1'b1) >> 1;
    tu_rnd = ((QuotW+1)'(col_quo[K] >> (K - TexW)) + 1'b1) >> 1;
    el_ang = ANGLE_BITS'((ANGLE_BITS+1)'(1) << (ANGLE_BITS - 2))
           - el_rnd[ANGLE_BITS-1:0];
    az_ang = az_rnd[ANGLE_BITS-1:0];
  end

  function automatic cord_lane_t lane_init(input logic [ANGLE_BITS-1:0] a);
    cord_lane_t  l;
    logic [31:0] ang, z32;
    ang    = 32'(a) << (32 - ANGLE_BITS);
    l.quad = 2'((ang + 32'h2000_0000) >> 30);
    z32    = ang - {l.quad, 30'b0};
    l.x    = GainQ30;
    l.y    = '0;
    l.z    = {z32[31], z32};
    return l;
  endfunction

  // cordic chain, elevation and azimuth lanes side by side
  logic [TRIG_STAGES:0] cv, cr;
  cord_lane_t           el_l [TRIG_STAGES+1];
  cord_lane_t           az_l [TRIG_STAGES+1];
  tex_t                 tex_l [TRIG_STAGES+1];

  assign cv[0]     = dv[K];
  assign dr[K]     = cr[0];
  assign el_l[0]   = lane_init(el_ang);
  assign az_l[0]   = lane_init(az_ang);
  assign tex_l[0].u = tu_rnd[TexW-1:0];
  assign tex_l[0].v = tv_rnd[TexW-1:0];

  for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cord
    uvs_cordic_cell #(.Idx(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[g]),
      .ready_o (cr[g]),
      .el_i    (el_l[g]),
      .az_i    (az_l[g]),
      .tex_i   (tex_l[g]),
      .valid_o (cv[g+1]),
      .ready_i (cr[g+1]),
      .el_o    (el_l[g+1]),
      .az_o    (az_l[g+1]),
      .tex_o   (tex_l[g+1])
    );
  end

  tex_t tex_out;

  uvs_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .radius_i (radius_q),
    .valid_i  (cv[TRIG_STAGES]),
    .ready_o  (cr[TRIG_STAGES]),
    .el_i     (el_l[TRIG_STAGES]),
    .az_i     (az_l[TRIG_STAGES]),
    .tex_i    (tex_l[TRIG_STAGES]),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .pos_x_o  (out_o.pos_x),
    .pos_y_o  (out_o.pos_y),
    .pos_z_o  (out_o.pos_z),
    .tex_o    (tex_out)
  );

  assign out_o.tex_u = tex_out.u;
  assign out_o.tex_v = tex_out.v;

endmodule
